// ----- hdl/gcc_pkg.sv -----
`default_nettype none
package gcc_pkg;

	localparam int COIN_W = 16;
	localparam int AMT_W  = 32;
	localparam int STEP_W = 5;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_ADD   = 2'd1,
		KIND_REQ   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_REQ_EMPTY,
		ST_REQ_RD,
		ST_REQ_CHK,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic cap;
		logic clr_set;
		logic rd;
		logic ins_shift;
		logic ins_place;
		logic div_start;
		logic div_step;
		logic emit;
		logic emit_empty;
	} cmd_t;

	typedef struct packed {
		logic held_zero;
		logic held_full;
		logic pos_zero;
		logic ins_greater;
		logic skip_div;
		logic div_done;
		logic out_free;
		logic last_coin;
	} stat_t;

endpackage
`default_nettype wire

// ----- hdl/greedy_coin_change.sv -----
`default_nettype none
// channel  dir  tdata (low bit up)                    tuser  tlast
// s_*      in   coin_value[15:0], amount[47:16]       kind   -
// m_*      out  coin[15:0], count[47:16], leftover    -      last
//               [79:48]
//
// clear: empties the coin count; add: reads and compares stored coins from the top, moving each
//   greater one up a slot for the sorted insert, then places the new coin
// request: per stored coin, store read, check, 32 divide steps, emit;
//   the divide is skipped once the remainder is zero or the coin is zero
// the 32-step serial divider runs once for each coin that is not skipped
// reset clears the coin count and control; store contents are undefined until written
// one result register; the block holds in emit while it is full and not taken
module greedy_coin_change #(
	parameter int MAX_COINS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // coin_value, amount
	input  wire logic [1:0]  s_tuser,   // kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,   // coin, count, leftover
	output logic             m_tlast    // last
);
	import gcc_pkg::*;

	cmd_t              cmd;
	stat_t             stat;
	logic [COIN_W-1:0] out_coin;
	logic [AMT_W-1:0]  out_count;
	logic [AMT_W-1:0]  out_leftover;

	gcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_kind  (s_tuser),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gcc_dpath #(
		.MAX_COINS (MAX_COINS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_coin_value (s_tdata[15:0]),
		.in_amount     (s_tdata[47:16]),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_coin      (out_coin),
		.out_count     (out_count),
		.out_leftover  (out_leftover),
		.out_last      (m_tlast)
	);

	assign m_tdata = {out_leftover, out_count, out_coin};

endmodule
`default_nettype wire

// ----- hdl/gcc_ctrl.sv -----
`default_nettype none
module gcc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic [1:0]     in_kind,
	output logic                in_ready,
	input  wire gcc_pkg::stat_t stat,
	output gcc_pkg::cmd_t       cmd
);
	import gcc_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_kind)
						KIND_ADD: begin
							if (!stat.held_full) state_d = ST_INS_RD;
						end
						KIND_REQ: begin
							state_d = stat.held_zero ? ST_REQ_EMPTY : ST_REQ_RD;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_INS_RD: begin
				state_d = stat.pos_zero ? ST_IDLE : ST_INS_CMP;
			end
			ST_INS_CMP: begin
				state_d = stat.ins_greater ? ST_INS_RD : ST_IDLE;
			end
			ST_REQ_EMPTY: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			ST_REQ_RD: begin
				state_d = ST_REQ_CHK;
			end
			ST_REQ_CHK: begin
				state_d = stat.skip_div ? ST_EMIT : ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) state_d = stat.last_coin ? ST_IDLE : ST_REQ_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.cap     = accept;
				cmd.clr_set = accept && (in_kind == KIND_CLEAR);
			end
			ST_INS_RD: begin
				cmd.ins_place = stat.pos_zero;
				cmd.rd        = !stat.pos_zero;
			end
			ST_INS_CMP: begin
				cmd.ins_shift = stat.ins_greater;
				cmd.ins_place = !stat.ins_greater;
			end
			ST_REQ_EMPTY: begin
				cmd.emit_empty = stat.out_free;
			end
			ST_REQ_RD: begin
				cmd.rd = 1'b1;
			end
			ST_REQ_CHK: begin
				cmd.div_start = !stat.skip_div;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = stat.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- hdl/gcc_dpath.sv -----
`default_nettype none
module gcc_dpath #(
	parameter int MAX_COINS = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire gcc_pkg::cmd_t                cmd,
	output gcc_pkg::stat_t                    stat,
	input  wire logic [gcc_pkg::COIN_W-1:0]   in_coin_value,
	input  wire logic [gcc_pkg::AMT_W-1:0]    in_amount,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [gcc_pkg::COIN_W-1:0]        out_coin,
	output logic [gcc_pkg::AMT_W-1:0]         out_count,
	output logic [gcc_pkg::AMT_W-1:0]         out_leftover,
	output logic                              out_last
);
	import gcc_pkg::*;

	localparam int CNT_W = $clog2(MAX_COINS + 1);
	localparam int IDX_W = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;

	logic [COIN_W-1:0] store_mem [MAX_COINS];
	logic [COIN_W-1:0] rd_data_q;

	logic [CNT_W-1:0]  held_q;
	logic [CNT_W-1:0]  pos_q;
	logic [CNT_W-1:0]  rd_ptr;
	logic [COIN_W-1:0] val_q;
	logic [AMT_W-1:0]  rem_q;

	logic [COIN_W-1:0] part_q;
	logic [AMT_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic [COIN_W:0]   trial;
	logic [COIN_W:0]   trial_diff;
	logic              trial_ge;

	logic              skip;
	logic [AMT_W-1:0]  new_rem;
	logic              out_valid_q;

	assign rd_ptr = pos_q - CNT_W'(1);

	// coin store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.ins_shift) begin
			store_mem[pos_q[IDX_W-1:0]] <= rd_data_q;
		end else if (cmd.ins_place) begin
			store_mem[pos_q[IDX_W-1:0]] <= val_q;
		end
		if (cmd.rd) begin
			rd_data_q <= store_mem[rd_ptr[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (cmd.clr_set) begin
			held_q <= '0;
		end else if (cmd.ins_place) begin
			held_q <= held_q + CNT_W'(1);
		end
	end

	// restoring division, one quotient bit a step
	assign trial      = {part_q, quo_q[AMT_W-1]};
	assign trial_ge   = (trial >= {1'b0, rd_data_q});
	assign trial_diff = trial - {1'b0, rd_data_q};

	assign skip    = (rd_data_q == '0) || (rem_q == '0);
	assign new_rem = skip ? rem_q : {{(AMT_W-COIN_W){1'b0}}, part_q};

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			val_q <= in_coin_value;
			rem_q <= in_amount;
			pos_q <= held_q;
		end else if (cmd.ins_shift || cmd.emit) begin
			pos_q <= rd_ptr;
		end
		if (cmd.emit) begin
			rem_q <= new_rem;
		end
		if (cmd.div_start) begin
			part_q <= '0;
			quo_q  <= rem_q;
			step_q <= '0;
		end else if (cmd.div_step) begin
			part_q <= trial_ge ? trial_diff[COIN_W-1:0] : trial[COIN_W-1:0];
			quo_q  <= {quo_q[AMT_W-2:0], trial_ge};
			step_q <= step_q + STEP_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.emit_empty) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_coin     <= rd_data_q;
			out_count    <= skip ? '0 : quo_q;
			out_leftover <= new_rem;
			out_last     <= (pos_q == CNT_W'(1));
		end else if (cmd.emit_empty) begin
			out_coin     <= '0;
			out_count    <= '0;
			out_leftover <= rem_q;
			out_last     <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		stat.held_zero   = (held_q == '0);
		stat.held_full   = (held_q == CNT_W'(MAX_COINS));
		stat.pos_zero    = (pos_q == '0);
		stat.ins_greater = (rd_data_q > val_q);
		stat.skip_div    = skip;
		stat.div_done    = (step_q == {STEP_W{1'b1}});
		stat.out_free    = !out_valid_q || out_ready;
		stat.last_coin   = (pos_q == CNT_W'(1));
	end

endmodule
`default_nettype wire
